/* hw/rtl/cmwc_pkg.sv */
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared types and constants for the CMWC4096 random generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        FUNC_GENERATE  = 3'd0,
        FUNC_ADVANCE   = 3'd1,
        FUNC_LOAD      = 3'd2,
        FUNC_MERGE     = 3'd3,
        FUNC_SET_CARRY = 3'd4
    } t_func;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned MULT_W  = 15;
    localparam int unsigned PROD_W  = 48;

    localparam logic [MULT_W-1:0] MWC_MULT = 15'd18782;
    localparam logic [WORD_W-1:0] MWC_BASE = 32'hffff_fffe;

    // Result of one multiply-with-carry step
    typedef struct packed {
        logic [WORD_W-1:0] lag_word;
        logic [WORD_W-1:0] carry;
    } t_step_result;

endpackage

`default_nettype wire

/* hw/rtl/cmwc_lag_mem.sv */
// ----------------------------------------------------------------------------
// cmwc_lag_mem
// Lag word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmwc_lag_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [AW-1:0]                  i_wr_addr,
    input  wire logic [cmwc_pkg::WORD_W-1:0]    i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [AW-1:0]                  i_rd_addr,
    output      logic [cmwc_pkg::WORD_W-1:0]    o_rd_data
);

    logic [cmwc_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [cmwc_pkg::WORD_W-1:0] r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one word; old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/cmwc_step.sv */
// ----------------------------------------------------------------------------
// cmwc_step
// One complementary multiply-with-carry step: t = a*Q + c, new carry and word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmwc_step (
    input  wire logic [cmwc_pkg::WORD_W-1:0] i_lag_word,
    input  wire logic [cmwc_pkg::WORD_W-1:0] i_carry,
    output      cmwc_pkg::t_step_result      o_result
);

    logic [cmwc_pkg::PROD_W-1:0] prod;
    logic [cmwc_pkg::WORD_W-1:0] hi;
    logic [cmwc_pkg::WORD_W:0]   sum;
    logic [cmwc_pkg::WORD_W-1:0] x;
    logic [cmwc_pkg::WORD_W-1:0] c;

    // Multiply-add in 48 bits, split into carry and low half
    assign prod = ({{(cmwc_pkg::PROD_W-cmwc_pkg::MULT_W){1'b0}}, cmwc_pkg::MWC_MULT}
                   * {{(cmwc_pkg::PROD_W-cmwc_pkg::WORD_W){1'b0}}, i_lag_word})
                  + {{(cmwc_pkg::PROD_W-cmwc_pkg::WORD_W){1'b0}}, i_carry};
    assign hi   = {{(2*cmwc_pkg::WORD_W-cmwc_pkg::PROD_W){1'b0}},
                   prod[cmwc_pkg::PROD_W-1:cmwc_pkg::WORD_W]};

    // Add carry to low half; correct both on wrap
    assign sum = {1'b0, prod[cmwc_pkg::WORD_W-1:0]} + {1'b0, hi};

    always_comb begin
        if (sum[cmwc_pkg::WORD_W]) begin
            x = sum[cmwc_pkg::WORD_W-1:0] + 32'd1;
            c = hi + 32'd1;
        end else begin
            x = sum[cmwc_pkg::WORD_W-1:0];
            c = hi;
        end
    end

    assign o_result.lag_word = cmwc_pkg::MWC_BASE - x;
    assign o_result.carry    = c;

endmodule

`default_nettype wire

/* hw/rtl/cmwc4096_random_generator.sv */
// ----------------------------------------------------------------------------
// cmwc4096_random_generator
// CMWC4096 generator: lag word store, carry and index with host seeding items.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                         | Direction
//  ---------+-------------------------------------------------+----------
//  command  | i_valid o_ready i_func i_word_index i_data_word | in
//  result   | o_valid i_ready o_random_value                  | out
//
//  One item per cycle while no result is stalled. An accepted item reads its lag
//  word from the store port, the next cycle does the multiply-add and writes
//  back; a result is registered into the output register from the compute
//  stage, with the carry loop closed inside that stage and a one-entry bypass
//  for back-to-back words. After reset a clearing pass writes zero to all
//  LAG_DEPTH words, one per cycle, with o_ready low.
//  A stalled result holds the compute stage and drops o_ready until it moves.
//
`timescale 1ns / 1ps
`default_nettype none

module cmwc4096_random_generator #(
    parameter int unsigned LAG_DEPTH = 4096,
    parameter int unsigned AW        = $clog2(LAG_DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [2:0]                  i_func,
    input  wire logic [AW-1:0]               i_word_index,
    input  wire logic [cmwc_pkg::WORD_W-1:0] i_data_word,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic [cmwc_pkg::WORD_W-1:0] o_random_value
);

    localparam logic [AW-1:0] LAST_IDX = AW'(LAG_DEPTH - 1);

    // Control state
    logic                        r_clr_active;
    logic [AW-1:0]               r_clr_addr;
    logic [AW-1:0]               r_lag_index;
    logic [cmwc_pkg::WORD_W-1:0] r_carry;
    logic                        r_b_valid;
    logic                        r_fwd_valid;
    logic                        r_o_valid;

    // Payload state
    cmwc_pkg::t_func             r_b_func;
    logic [AW-1:0]               r_b_addr;
    logic [cmwc_pkg::WORD_W-1:0] r_b_data;
    logic [cmwc_pkg::WORD_W-1:0] r_fwd_data;
    logic [cmwc_pkg::WORD_W-1:0] r_o_data;

    cmwc_pkg::t_func             in_func;
    logic                        in_fire;
    logic                        in_step;
    logic                        in_rd;
    logic [AW-1:0]               rd_addr;
    logic [cmwc_pkg::WORD_W-1:0] rd_data;
    logic [cmwc_pkg::WORD_W-1:0] operand;

    logic                        b_step;
    logic                        b_gen;
    logic                        b_stall;
    logic                        b_wr;
    logic [cmwc_pkg::WORD_W-1:0] b_wr_data;
    cmwc_pkg::t_step_result      step_res;

    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [cmwc_pkg::WORD_W-1:0] mem_wr_data;

    // Decode the incoming item
    assign in_func = cmwc_pkg::t_func'(i_func);
    assign in_step = (in_func == cmwc_pkg::FUNC_GENERATE)
                  || (in_func == cmwc_pkg::FUNC_ADVANCE);
    assign in_rd   = in_step || (in_func == cmwc_pkg::FUNC_MERGE);
    assign rd_addr = in_step ? (r_lag_index + AW'(1)) : i_word_index;

    // Compute stage decode and stall
    assign b_gen   = (r_b_func == cmwc_pkg::FUNC_GENERATE);
    assign b_step  = b_gen || (r_b_func == cmwc_pkg::FUNC_ADVANCE);
    assign b_stall = r_b_valid && b_gen && r_o_valid && !i_ready;
    assign b_wr    = r_b_valid && !b_stall
                  && (b_step || (r_b_func == cmwc_pkg::FUNC_LOAD)
                      || (r_b_func == cmwc_pkg::FUNC_MERGE));

    assign o_ready = !r_clr_active && !b_stall;
    assign in_fire = i_valid && o_ready;

    // Pick the bypassed word when the previous item just wrote it
    assign operand = r_fwd_valid ? r_fwd_data : rd_data;

    cmwc_step u_step (
        .i_lag_word (operand),
        .i_carry    (r_carry),
        .o_result   (step_res)
    );

    // Select write-back data per operation
    always_comb begin
        unique case (r_b_func)
            cmwc_pkg::FUNC_GENERATE,
            cmwc_pkg::FUNC_ADVANCE: b_wr_data = step_res.lag_word;
            cmwc_pkg::FUNC_MERGE:   b_wr_data = operand ^ r_b_data;
            default:                b_wr_data = r_b_data;
        endcase
    end

    // Store write port: clearing pass first, then compute stage
    always_comb begin
        if (r_clr_active) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_clr_addr;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = b_wr;
            mem_wr_addr = r_b_addr;
            mem_wr_data = b_wr_data;
        end
    end

    cmwc_lag_mem #(
        .DEPTH (LAG_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (in_fire && in_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sweep the store to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_IDX) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Advance or restart the lag index at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_index <= LAST_IDX;
        end else if (in_fire) begin
            if (in_step) begin
                r_lag_index <= rd_addr;
            end else if (in_func == cmwc_pkg::FUNC_SET_CARRY) begin
                r_lag_index <= LAST_IDX;
            end
        end
    end

    // Load the compute stage and note a same-word bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_b_valid <= in_fire || b_stall;
            if (in_fire) begin
                r_fwd_valid <= b_wr && (r_b_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_func   <= in_func;
            r_b_addr   <= rd_addr;
            r_b_data   <= i_data_word;
            r_fwd_data <= b_wr_data;
        end
    end

    // Update the carry in the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else if (r_b_valid && !b_stall) begin
            if (b_step) begin
                r_carry <= step_res.carry;
            end else if (r_b_func == cmwc_pkg::FUNC_SET_CARRY) begin
                r_carry <= r_b_data;
            end
        end
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_b_valid && b_gen && !b_stall) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && b_gen && !b_stall) begin
            r_o_data <= step_res.lag_word;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_random_value = r_o_data;

endmodule

`default_nettype wire

/* verif/tb_cmwc4096_random_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cmwc4096_random_generator
// Drives command items into the CMWC4096 generator and checks each random
// number against an in-bench multiply-with-carry predictor that tracks the
// lag words, the carry and the index. Directed items cover reset state, host
// seeding, unused codes and the carry wrap. Random phases mix all commands
// under several idle and stall rates.
// ----------------------------------------------------------------------------

module tb_cmwc4096_random_generator;

    localparam int unsigned LAG_DEPTH    = 4096;
    localparam logic [31:0] STEP_MULT    = 32'd18782;
    localparam logic [31:0] STEP_BASE    = 32'hffff_fffe;
    localparam logic [11:0] LAST_SLOT    = 12'd4095;
    localparam logic [2:0]  FUNC_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]  FUNC_RESERVED_LAST  = 3'd7;
    // With lag word 0xffffffff this carry makes the low-half add wrap
    localparam logic [31:0] WRAP_CARRY   = 32'd18781;
    localparam logic [31:0] CARRY_CEIL   = 32'd18782;
    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 240;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func       = 3'd0;
    logic [11:0] i_word_index = 12'd0;
    logic [31:0] i_data_word  = 32'd0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [31:0] o_random_value;

    // Predicted generator state
    logic [31:0] lag_store [LAG_DEPTH];
    logic [31:0] carry_reg;
    logic [11:0] lag_ptr;

    logic [31:0] expected_numbers [$];
    logic [31:0] wanted_number;
    int unsigned fail_count    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    cmwc4096_random_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_word_index   (i_word_index),
        .i_data_word    (i_data_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Clear predicted state to its reset values
    task automatic clear_generator_state();
        foreach (lag_store[n]) lag_store[n] = 32'd0;
        carry_reg = 32'd0;
        lag_ptr   = LAST_SLOT;
    endtask

    // Advance the index and run one multiply-with-carry step
    function automatic logic [31:0] next_random_number();
        logic [63:0] prod;
        logic [31:0] sum;
        lag_ptr   = lag_ptr + 12'd1;
        prod      = {32'd0, STEP_MULT} * {32'd0, lag_store[lag_ptr]} + {32'd0, carry_reg};
        carry_reg = prod[63:32];
        sum       = prod[31:0] + carry_reg;
        if (sum < carry_reg) begin
            sum       = sum + 32'd1;
            carry_reg = carry_reg + 32'd1;
        end
        lag_store[lag_ptr] = STEP_BASE - sum;
        return lag_store[lag_ptr];
    endfunction

    // Apply one accepted item to the predicted state
    task automatic apply_command(input logic [2:0] func, input logic [11:0] idx,
                                 input logic [31:0] data);
        case (func)
            cmwc_pkg::FUNC_GENERATE: expected_numbers.push_back(next_random_number());
            cmwc_pkg::FUNC_ADVANCE:  void'(next_random_number());
            cmwc_pkg::FUNC_LOAD:     lag_store[idx] = data;
            cmwc_pkg::FUNC_MERGE:    lag_store[idx] = lag_store[idx] ^ data;
            cmwc_pkg::FUNC_SET_CARRY: begin
                carry_reg = data;
                lag_ptr   = LAST_SLOT;
            end
            default: ;
        endcase
    endtask

    // Present one item, hold it until accepted, then predict
    task automatic send_item(input logic [2:0] func, input logic [11:0] idx,
                             input logic [31:0] data);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_word_index <= idx;
        i_data_word  <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_command(func, idx, data);
    endtask

    // Drop valid and wait until every expected number has come back
    task automatic finish_phase();
        i_valid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Data word biased toward the extremes
    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0) return 32'd0;
        if (sel == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Carry and lag word chosen so the low-half add wraps on the next step
    task automatic send_carry_wrap();
        send_item(cmwc_pkg::FUNC_SET_CARRY, 12'($urandom_range(4095)), WRAP_CARRY);
        send_item(cmwc_pkg::FUNC_LOAD, 12'd0, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_GENERATE, 12'($urandom_range(4095)), $urandom);
    endtask

    // First numbers out of a freshly cleared store
    task automatic test_reset_state();
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
        send_item(cmwc_pkg::FUNC_GENERATE, LAST_SLOT, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_ADVANCE, 12'd0, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_GENERATE, LAST_SLOT, 32'd0);
    endtask

    // Load and merge at word 4 and the last word, then extreme carry
    task automatic test_host_seeding();
        send_item(cmwc_pkg::FUNC_LOAD, 12'd4, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_MERGE, 12'd4, 32'h0000_ffff);
        send_item(cmwc_pkg::FUNC_LOAD, LAST_SLOT, 32'd0);
        send_item(cmwc_pkg::FUNC_MERGE, LAST_SLOT, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_LOAD, 12'd5, 32'd0);
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
        send_item(cmwc_pkg::FUNC_SET_CARRY, 12'd0, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
    endtask

    // Unused codes must leave the state alone
    task automatic test_unused_codes();
        int code;
        for (code = FUNC_RESERVED_FIRST; code <= FUNC_RESERVED_LAST; code++) begin
            send_item(3'(code), LAST_SLOT, 32'hffff_ffff);
        end
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
    endtask

    // Low-half add that wraps and bumps both sum and carry
    task automatic test_carry_wrap();
        send_carry_wrap();
        send_item(cmwc_pkg::FUNC_GENERATE, 12'd0, 32'd0);
    endtask

    // Mostly steps with seeding mixed in, plus noise
    task automatic run_random_items(input int unsigned count);
        int unsigned sent;
        int unsigned kind;
        logic [11:0] idx;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            // Aim seeding at words the next steps will read
            if ($urandom_range(1) == 0) idx = lag_ptr + 12'($urandom_range(1, 8));
            else idx = 12'($urandom_range(4095));
            if (kind < 48) begin
                send_item(cmwc_pkg::FUNC_GENERATE, idx, $urandom);
            end else if (kind < 63) begin
                send_item(cmwc_pkg::FUNC_ADVANCE, idx, $urandom);
            end else if (kind < 73) begin
                send_item(cmwc_pkg::FUNC_LOAD, idx, pick_word());
            end else if (kind < 82) begin
                send_item(cmwc_pkg::FUNC_MERGE, idx, pick_word());
            end else if (kind < 87) begin
                if ($urandom_range(3) == 0) send_item(cmwc_pkg::FUNC_SET_CARRY, idx, pick_word());
                else send_item(cmwc_pkg::FUNC_SET_CARRY, idx, $urandom_range(CARRY_CEIL));
            end else if (kind < 91) begin
                // Ignored item: does not count toward the phase
                send_item(3'($urandom_range(FUNC_RESERVED_FIRST, FUNC_RESERVED_LAST)),
                          idx, $urandom);
                sent--;
            end else begin
                send_carry_wrap();
            end
            sent++;
        end
    endtask

    // Result side stalls at the current rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_numbers.size() == 0) begin
                $error("random_value: expected none, got %h", o_random_value);
                fail_count++;
            end else begin
                wanted_number = expected_numbers.pop_front();
                if (o_random_value !== wanted_number) begin
                    $error("random_value: expected %h, got %h", wanted_number, o_random_value);
                    fail_count++;
                end
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL cmwc4096_random_generator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_generator_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_host_seeding();
        test_unused_codes();
        test_carry_wrap();
        finish_phase();

        // Random phases: no idling, sender idle, receiver stall, both
        run_random_items(PHASE_ITEMS);
        finish_phase();
        send_idle_pct = 53;
        run_random_items(PHASE_ITEMS);
        finish_phase();
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        run_random_items(PHASE_ITEMS);
        finish_phase();
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_random_items(PHASE_ITEMS);
        finish_phase();

        if (fail_count == 0) begin
            $display("PASS cmwc4096_random_generator");
        end else begin
            $display("FAIL cmwc4096_random_generator");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cmwc_pkg.sv
hw/rtl/cmwc_lag_mem.sv
hw/rtl/cmwc_step.sv
hw/rtl/cmwc4096_random_generator.sv
verif/tb_cmwc4096_random_generator.sv
